// ----- src/aab_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aab_pkg
// Shared types, codes and helpers of the accelerated bisection root finder.
// ----------------------------------------------------------------------------
package aab_pkg;

   localparam int FRAC_BITS = 40;
   localparam int VAL_W     = 64;
   localparam int TOL_W     = 63;
   localparam int ITER_W    = 10;
   localparam int EVAL_W    = 12;
   localparam int ADDR_W    = 4;
   localparam int STEP_W    = 6;

   localparam logic [TOL_W-1:0]  TOL_RESET     = 63'd1099512;
   localparam logic [ITER_W-1:0] MAX_ITER_RESET = 10'd100;
   localparam logic [ITER_W-1:0] ROUND_MAX     = {ITER_W{1'b1}};
   localparam logic [EVAL_W-1:0] EVAL_MAX      = {EVAL_W{1'b1}};
   // aitken denominator threshold, 1e-10 in lsb units
   localparam logic [VAL_W-1:0]  AITKEN_MIN =
      ((64'd1 << FRAC_BITS) + 64'd5000000000) / 64'd10000000000;

   // register index codes
   localparam logic REG_TOLERANCE = 1'b0;
   localparam logic REG_MAX_ITER  = 1'b1;

   typedef enum logic [1:0] {
      KIND_EVAL    = 2'd0,
      KIND_ROOT    = 2'd1,
      KIND_NOSIGN  = 2'd2,
      KIND_IGNORED = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE, PH_WLO, PH_WHI, PH_M1, PH_M2, PH_M3, PH_ACC
   } phase_type;

   typedef enum logic [3:0] {
      ST_READY, ST_NEXT, ST_MID, ST_FIN, ST_AIT_PREP, ST_AIT_CHECK, ST_MUL,
      ST_QCHECK, ST_DIV, ST_BOUND, ST_INSIDE, ST_EMIT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_START, OP_IGNORE, OP_WLO, OP_WHI, OP_MID_UPD, OP_M3, OP_ACC,
      OP_FIN, OP_NEXT, OP_MID, OP_AIT_PREP, OP_MUL_STEP, OP_DIV_STEP,
      OP_BOUND, OP_AIT_EMIT, OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   mid_sel;   // 0: first midpoint / writes second, 1: second / third
   } cmd_type;

   typedef struct packed {
      logic whi_opp;
      logic acc_lo;
      logic acc_hi;
      logic next_go;
      logic md_small;
      logic quot_big;
      logic inside_ok;
      logic step_done;
      logic out_free;
   } stat_type;

   function automatic logic opposite(input logic [VAL_W-1:0] x,
                                     input logic [VAL_W-1:0] y);
      logic xn, xp, yn, yp;
      xn = x[VAL_W-1];
      yn = y[VAL_W-1];
      xp = (x != '0) && !xn;
      yp = (y != '0) && !yn;
      return (xn && yp) || (xp && yn);
   endfunction

   function automatic logic [VAL_W-1:0] midpoint(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
      logic [VAL_W:0] s;
      s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
      return s[VAL_W:1];
   endfunction

endpackage

// ----- src/aitken_accelerated_bisection.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aitken_accelerated_bisection
// Bracketing root finder with aitken acceleration driving an external f unit.
// ----------------------------------------------------------------------------
// every item gets exactly one result item: a point to evaluate, the root, a
// no-sign-change error or an ignored mark. one item is worked on at a time.
// the reply to the third midpoint of a round skips the aitken step when the
// aitken denominator is too small, skips the divide when the quotient would
// not fit, and else takes the aitken quotient from a serial shift-add squarer
// and a restoring divider, one bit per cycle.
// a new item is taken while the previous result still waits in the output
// register; the one after that stalls until the output register frees up.
// values are signed q23.40.
// ----------------------------------------------------------------------------
module aitken_accelerated_bisection (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_func,
   input  logic signed [aab_pkg::VAL_W-1:0] req_lower_end,
   input  logic signed [aab_pkg::VAL_W-1:0] req_upper_end,
   input  logic signed [aab_pkg::VAL_W-1:0] req_function_value,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_kind,
   output logic signed [aab_pkg::VAL_W-1:0] rsp_point,
   output logic [aab_pkg::ITER_W-1:0]       rsp_rounds_done,
   output logic [aab_pkg::EVAL_W-1:0]       rsp_evaluations,
   // register port: tolerance at 0x0, iteration limit at 0x8
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [aab_pkg::ADDR_W-1:0]       paddr,
   input  logic [63:0]                      pwdata,
   output logic [63:0]                      prdata,
   output logic                             pready
);

   aab_pkg::cmd_type  cmd;
   aab_pkg::stat_type stat;

   // registers take writes with no wait states
   assign pready = 1'b1;

   // sequencer: holds the search phase, steps through the aitken unit
   aab_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // bracket state, serial arithmetic, config and result register
   aab_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_lower_end      (req_lower_end),
      .req_upper_end      (req_upper_end),
      .req_function_value (req_function_value),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_kind           (rsp_kind),
      .rsp_point          (rsp_point),
      .rsp_rounds_done    (rsp_rounds_done),
      .rsp_evaluations    (rsp_evaluations)
   );

endmodule

// ----- src/aab_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aab_ctrl
// Sequencer: search phase and per-item step state, issues datapath commands.
// ----------------------------------------------------------------------------
module aab_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_func,
   output logic              req_stall,
   input  aab_pkg::stat_type stat,
   output aab_pkg::cmd_type  cmd
);

   aab_pkg::state_type state_ff, state_in;
   aab_pkg::phase_type phase_ff, phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aab_pkg::ST_READY;
         phase_ff <= aab_pkg::PH_IDLE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   assign req_stall = (state_ff != aab_pkg::ST_READY);

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      cmd.op      = aab_pkg::OP_NONE;
      cmd.mid_sel = 1'b0;
      case (state_ff)
         aab_pkg::ST_READY: begin
            if (req_valid) begin
               if (!req_func) begin
                  cmd.op   = aab_pkg::OP_START;
                  phase_in = aab_pkg::PH_WLO;
                  state_in = aab_pkg::ST_EMIT;
               end else begin
                  case (phase_ff)
                     aab_pkg::PH_WLO: begin
                        cmd.op   = aab_pkg::OP_WLO;
                        phase_in = aab_pkg::PH_WHI;
                        state_in = aab_pkg::ST_EMIT;
                     end
                     aab_pkg::PH_WHI: begin
                        cmd.op = aab_pkg::OP_WHI;
                        if (stat.whi_opp) begin
                           state_in = aab_pkg::ST_NEXT;
                        end else begin
                           phase_in = aab_pkg::PH_IDLE;
                           state_in = aab_pkg::ST_EMIT;
                        end
                     end
                     aab_pkg::PH_M1: begin
                        cmd.op   = aab_pkg::OP_MID_UPD;
                        state_in = aab_pkg::ST_MID;
                     end
                     aab_pkg::PH_M2: begin
                        cmd.op      = aab_pkg::OP_MID_UPD;
                        cmd.mid_sel = 1'b1;
                        state_in    = aab_pkg::ST_MID;
                     end
                     aab_pkg::PH_M3: begin
                        cmd.op   = aab_pkg::OP_M3;
                        state_in = aab_pkg::ST_AIT_PREP;
                     end
                     aab_pkg::PH_ACC: begin
                        cmd.op   = aab_pkg::OP_ACC;
                        state_in = (stat.acc_lo || stat.acc_hi) ?
                                   aab_pkg::ST_NEXT : aab_pkg::ST_FIN;
                     end
                     default: begin
                        cmd.op   = aab_pkg::OP_IGNORE;
                        phase_in = aab_pkg::PH_IDLE;
                        state_in = aab_pkg::ST_EMIT;
                     end
                  endcase
               end
            end
         end
         aab_pkg::ST_NEXT: begin
            cmd.op   = aab_pkg::OP_NEXT;
            phase_in = stat.next_go ? aab_pkg::PH_M1 : aab_pkg::PH_IDLE;
            state_in = aab_pkg::ST_EMIT;
         end
         aab_pkg::ST_MID: begin
            cmd.op      = aab_pkg::OP_MID;
            cmd.mid_sel = (phase_ff == aab_pkg::PH_M2);
            phase_in    = (phase_ff == aab_pkg::PH_M2) ? aab_pkg::PH_M3 : aab_pkg::PH_M2;
            state_in    = aab_pkg::ST_EMIT;
         end
         aab_pkg::ST_FIN: begin
            cmd.op   = aab_pkg::OP_FIN;
            state_in = aab_pkg::ST_NEXT;
         end
         aab_pkg::ST_AIT_PREP: begin
            cmd.op   = aab_pkg::OP_AIT_PREP;
            state_in = aab_pkg::ST_AIT_CHECK;
         end
         aab_pkg::ST_AIT_CHECK: begin
            state_in = stat.md_small ? aab_pkg::ST_FIN : aab_pkg::ST_MUL;
         end
         aab_pkg::ST_MUL: begin
            cmd.op = aab_pkg::OP_MUL_STEP;
            if (stat.step_done) state_in = aab_pkg::ST_QCHECK;
         end
         aab_pkg::ST_QCHECK: begin
            state_in = stat.quot_big ? aab_pkg::ST_FIN : aab_pkg::ST_DIV;
         end
         aab_pkg::ST_DIV: begin
            cmd.op = aab_pkg::OP_DIV_STEP;
            if (stat.step_done) state_in = aab_pkg::ST_BOUND;
         end
         aab_pkg::ST_BOUND: begin
            cmd.op   = aab_pkg::OP_BOUND;
            state_in = aab_pkg::ST_INSIDE;
         end
         aab_pkg::ST_INSIDE: begin
            if (stat.inside_ok) begin
               cmd.op   = aab_pkg::OP_AIT_EMIT;
               phase_in = aab_pkg::PH_ACC;
               state_in = aab_pkg::ST_EMIT;
            end else begin
               state_in = aab_pkg::ST_FIN;
            end
         end
         aab_pkg::ST_EMIT: begin
            if (stat.out_free) begin
               cmd.op   = aab_pkg::OP_EMIT;
               state_in = aab_pkg::ST_READY;
            end
         end
         default: begin
            state_in = aab_pkg::ST_READY;
         end
      endcase
   end

endmodule

// ----- src/aab_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aab_dpath
// Bracket registers, serial square and divide unit, config and result register.
// ----------------------------------------------------------------------------
module aab_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  aab_pkg::cmd_type                    cmd,
   output aab_pkg::stat_type                   stat,
   input  logic signed [aab_pkg::VAL_W-1:0]    req_lower_end,
   input  logic signed [aab_pkg::VAL_W-1:0]    req_upper_end,
   input  logic signed [aab_pkg::VAL_W-1:0]    req_function_value,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [aab_pkg::ADDR_W-1:0]          paddr,
   input  logic [63:0]                         pwdata,
   output logic [63:0]                         prdata,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_kind,
   output logic signed [aab_pkg::VAL_W-1:0]    rsp_point,
   output logic [aab_pkg::ITER_W-1:0]          rsp_rounds_done,
   output logic [aab_pkg::EVAL_W-1:0]          rsp_evaluations
);

   localparam int W = aab_pkg::VAL_W;

   logic [W-1:0] low_ff, high_ff, flow_ff, fhigh_ff;
   logic [W-1:0] m1_ff, m2_ff, m3_ff, fm3_ff, acc_ff;
   logic [aab_pkg::ITER_W-1:0] round_ff, maxit_ff;
   logic [aab_pkg::EVAL_W-1:0] eval_ff;
   logic [aab_pkg::TOL_W-1:0]  tol_ff;
   logic [1:0]   pend_kind_ff;
   logic [W-1:0] pend_point_ff;
   logic [2*W-1:0] prod_ff;       // square, then remainder and quotient
   logic [W-1:0] mabs_ff, md_ff;
   logic         den_neg_ff, bound_ok_ff;
   logic [aab_pkg::STEP_W-1:0] step_ff;
   logic         rsp_valid_ff;
   logic [1:0]   rsp_kind_ff;
   logic [W-1:0] rsp_point_ff;
   logic [aab_pkg::ITER_W-1:0] rsp_rounds_ff;
   logic [aab_pkg::EVAL_W-1:0] rsp_evals_ff;

   logic [W-1:0] fv, mid_lh, width, d1, den, q, span_lo, span_hi, upd_pt;
   logic [W:0]   mul_sum, div_t, div_sub;
   logic         div_ge, upd_opp, cfg_wr;
   logic [aab_pkg::EVAL_W-1:0] eval_inc;
   logic [aab_pkg::ITER_W-1:0] round_inc;

   assign fv        = req_function_value;
   assign mid_lh    = aab_pkg::midpoint(low_ff, high_ff);
   assign width     = high_ff - low_ff;
   assign d1        = m2_ff - m1_ff;
   assign den       = (m3_ff - m2_ff) - d1;
   assign q         = prod_ff[W-1:0];
   assign span_lo   = m1_ff - low_ff;
   assign span_hi   = high_ff - m1_ff;
   assign eval_inc  = (eval_ff == aab_pkg::EVAL_MAX) ? eval_ff : eval_ff + 1'b1;
   assign round_inc = (round_ff == aab_pkg::ROUND_MAX) ? round_ff : round_ff + 1'b1;
   assign mul_sum   = {1'b0, prod_ff[2*W-1:W]} + (prod_ff[0] ? {1'b0, mabs_ff} : '0);
   assign div_t     = {prod_ff[2*W-1:W], prod_ff[W-1]};
   assign div_ge    = div_t >= {1'b0, md_ff};
   assign div_sub   = div_t - {1'b0, md_ff};
   assign upd_pt    = cmd.mid_sel ? m2_ff : m1_ff;
   assign upd_opp   = aab_pkg::opposite(fv, flow_ff);
   assign cfg_wr    = psel && penable && pwrite;

   assign stat.whi_opp   = aab_pkg::opposite(flow_ff, fv);
   assign stat.acc_lo    = upd_opp;
   assign stat.acc_hi    = aab_pkg::opposite(fv, fhigh_ff);
   assign stat.next_go   = ($signed(low_ff) < $signed(high_ff)) &&
                           (width > {1'b0, tol_ff}) && (round_ff < maxit_ff);
   assign stat.md_small  = (md_ff <= aab_pkg::AITKEN_MIN);
   assign stat.quot_big  = (prod_ff[2*W-1:W] >= md_ff);
   assign stat.inside_ok = bound_ok_ff && ($signed(low_ff) < $signed(acc_ff)) &&
                           ($signed(acc_ff) < $signed(high_ff));
   assign stat.step_done = (step_ff == {aab_pkg::STEP_W{1'b1}});
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   assign prdata = (paddr[3] == aab_pkg::REG_MAX_ITER) ?
                   {{(64-aab_pkg::ITER_W){1'b0}}, maxit_ff} : {1'b0, tol_ff};

   // control state and config
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff       <= aab_pkg::TOL_RESET;
         maxit_ff     <= aab_pkg::MAX_ITER_RESET;
         round_ff     <= '0;
         eval_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         if (cfg_wr) begin
            if (paddr[3] == aab_pkg::REG_TOLERANCE) tol_ff <= pwdata[aab_pkg::TOL_W-1:0];
            else maxit_ff <= pwdata[aab_pkg::ITER_W-1:0];
         end
         if (cmd.op == aab_pkg::OP_EMIT) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         case (cmd.op)
            aab_pkg::OP_START: begin
               round_ff <= '0;
               eval_ff  <= '0;
            end
            aab_pkg::OP_WLO, aab_pkg::OP_WHI, aab_pkg::OP_MID_UPD,
            aab_pkg::OP_M3: eval_ff <= eval_inc;
            aab_pkg::OP_ACC: begin
               eval_ff <= eval_inc;
               if (stat.acc_lo || stat.acc_hi) round_ff <= round_inc;
            end
            aab_pkg::OP_FIN: round_ff <= round_inc;
            aab_pkg::OP_AIT_PREP: step_ff <= '0;
            aab_pkg::OP_MUL_STEP, aab_pkg::OP_DIV_STEP: step_ff <= step_ff + 1'b1;
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         aab_pkg::OP_START: begin
            low_ff        <= req_lower_end;
            high_ff       <= req_upper_end;
            pend_kind_ff  <= aab_pkg::KIND_EVAL;
            pend_point_ff <= req_lower_end;
         end
         aab_pkg::OP_IGNORE: begin
            pend_kind_ff  <= aab_pkg::KIND_IGNORED;
            pend_point_ff <= '0;
         end
         aab_pkg::OP_WLO: begin
            flow_ff       <= fv;
            pend_kind_ff  <= aab_pkg::KIND_EVAL;
            pend_point_ff <= high_ff;
         end
         aab_pkg::OP_WHI: begin
            fhigh_ff      <= fv;
            pend_kind_ff  <= aab_pkg::KIND_NOSIGN;
            pend_point_ff <= '0;
         end
         aab_pkg::OP_MID_UPD: begin
            if (upd_opp) begin
               high_ff  <= upd_pt;
               fhigh_ff <= fv;
            end else begin
               low_ff  <= upd_pt;
               flow_ff <= fv;
            end
         end
         aab_pkg::OP_M3: fm3_ff <= fv;
         aab_pkg::OP_ACC: begin
            if (upd_opp) begin
               high_ff  <= acc_ff;
               fhigh_ff <= fv;
            end else if (stat.acc_hi) begin
               low_ff  <= acc_ff;
               flow_ff <= fv;
            end
         end
         aab_pkg::OP_FIN: begin
            if (aab_pkg::opposite(fm3_ff, flow_ff)) begin
               high_ff  <= m3_ff;
               fhigh_ff <= fm3_ff;
            end else begin
               low_ff  <= m3_ff;
               flow_ff <= fm3_ff;
            end
         end
         aab_pkg::OP_NEXT: begin
            pend_point_ff <= mid_lh;
            if (stat.next_go) begin
               m1_ff        <= mid_lh;
               pend_kind_ff <= aab_pkg::KIND_EVAL;
            end else begin
               pend_kind_ff <= aab_pkg::KIND_ROOT;
            end
         end
         aab_pkg::OP_MID: begin
            if (cmd.mid_sel) m3_ff <= mid_lh;
            else m2_ff <= mid_lh;
            pend_kind_ff  <= aab_pkg::KIND_EVAL;
            pend_point_ff <= mid_lh;
         end
         aab_pkg::OP_AIT_PREP: begin
            mabs_ff    <= d1[W-1] ? -d1 : d1;
            md_ff      <= den[W-1] ? -den : den;
            den_neg_ff <= den[W-1];
            prod_ff    <= {{W{1'b0}}, (d1[W-1] ? -d1 : d1)};
         end
         aab_pkg::OP_MUL_STEP: prod_ff <= {mul_sum, prod_ff[W-1:1]};
         aab_pkg::OP_DIV_STEP: begin
            prod_ff <= {(div_ge ? div_sub[W-1:0] : div_t[W-1:0]), prod_ff[W-2:0], div_ge};
         end
         aab_pkg::OP_BOUND: begin
            if (!den_neg_ff) begin
               bound_ok_ff <= !(($signed(m1_ff) < $signed(low_ff)) || (q >= span_lo));
               acc_ff      <= m1_ff - q;
            end else begin
               bound_ok_ff <= !(($signed(high_ff) < $signed(m1_ff)) || (q >= span_hi));
               acc_ff      <= m1_ff + q;
            end
         end
         aab_pkg::OP_AIT_EMIT: begin
            pend_kind_ff  <= aab_pkg::KIND_EVAL;
            pend_point_ff <= acc_ff;
         end
         aab_pkg::OP_EMIT: begin
            rsp_kind_ff   <= pend_kind_ff;
            rsp_point_ff  <= pend_point_ff;
            rsp_rounds_ff <= round_ff;
            rsp_evals_ff  <= eval_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_point       = rsp_point_ff;
   assign rsp_rounds_done = rsp_rounds_ff;
   assign rsp_evaluations = rsp_evals_ff;

endmodule

// ----- src/aab_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aab_checker
// Port-level checks of the root finder, bound to the top level.
// ----------------------------------------------------------------------------
module aab_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [63:0] rsp_point,
   input logic [9:0]  rsp_rounds_done,
   input logic [11:0] rsp_evaluations
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_point) && $stable(rsp_kind))
      else $error("stalled result changed");

   // one item at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while busy");

   // error marks carry no point
   a_zero_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == aab_pkg::KIND_NOSIGN || rsp_kind == aab_pkg::KIND_IGNORED)
      |-> rsp_point == '0)
      else $error("error result with nonzero point");

   // sign test happens right after both end values
   a_nosign_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == aab_pkg::KIND_NOSIGN
      |-> rsp_rounds_done == '0 && rsp_evaluations == 12'd2)
      else $error("no-sign error with wrong counters");

endmodule

bind aitken_accelerated_bisection aab_checker u_aab_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_kind        (rsp_kind),
   .rsp_point       (rsp_point),
   .rsp_rounds_done (rsp_rounds_done),
   .rsp_evaluations (rsp_evaluations)
);
